// File: rtl/rtcp_pkg.sv
// Package for the RTCP compound parser: phase codes, packet types, field kinds,
// error codes, register indices and the result record type. No dependencies.
`default_nettype none
package rtcp_pkg;
	localparam logic [4:0] PH_HDR = 5'd0;
	localparam logic [4:0] PH_LOSS = 5'd8;
	localparam logic [4:0] PH_CHUNK = 5'd14;
	localparam logic [4:0] PH_ITYPE = 5'd15;
	localparam logic [4:0] PH_ILEN = 5'd16;
	localparam logic [4:0] PH_PNAME = 5'd17;
	localparam logic [4:0] PH_DATA = 5'd18;
	localparam logic [4:0] PH_PAD = 5'd19;
	localparam logic [4:0] PH_BSRC = 5'd20;
	localparam logic [4:0] PH_RLEN = 5'd21;
	localparam logic [4:0] PH_RTXT = 5'd22;
	localparam logic [4:0] PH_SKIP = 5'd23;
	localparam logic [4:0] PH_DROP = 5'd24;
	localparam logic [4:0] PH_PVAL = 5'd25;

	localparam logic [7:0] PT_SR = 8'd200;
	localparam logic [7:0] PT_RR = 8'd201;
	localparam logic [7:0] PT_SDES = 8'd202;
	localparam logic [7:0] PT_BYE = 8'd203;
	localparam logic [7:0] SDES_PRIV = 8'd8;

	localparam logic [4:0] K_HDR = 5'd0;
	localparam logic [4:0] K_FRAC = 5'd8;
	localparam logic [4:0] K_CUM = 5'd9;
	localparam logic [4:0] K_CSSRC = 5'd14;
	localparam logic [4:0] K_ITYPE = 5'd15;
	localparam logic [4:0] K_ILEN = 5'd16;
	localparam logic [4:0] K_IDATA = 5'd17;
	localparam logic [4:0] K_BSRC = 5'd18;
	localparam logic [4:0] K_RLEN = 5'd19;
	localparam logic [4:0] K_RTXT = 5'd20;

	localparam logic [2:0] E_OK = 3'd0;
	localparam logic [2:0] E_VER = 3'd1;
	localparam logic [2:0] E_FIRST = 3'd2;
	localparam logic [2:0] E_PAD = 3'd3;
	localparam logic [2:0] E_TRUNC = 3'd4;

	localparam logic [0:0] REG_CHECK = 1'd0;
	localparam logic [0:0] REG_VER = 1'd1;

	typedef struct packed {
		logic [7:0]  packet_type;
		logic [4:0]  field_kind;
		logic [31:0] field_value;
		logic [4:0]  entry_index;
		logic [2:0]  error_code;
		logic        end_of_packet;
		logic        end_of_datagram;
	} rec_t;
endpackage
`default_nettype wire

// File: rtl/rtcp_compound_parser.sv
// Top level of the RTCP compound parser: input register, decode core and
// result register. Depends on rtcp_pkg and rtcp_core.
`default_nettype none
// One byte is accepted per clock; each byte gives at most one result record,
// loaded into the result register once that register is free. The input
// register accepts a byte whenever it is empty or its byte moves on in the same
// cycle, so a stalled result holds the input only once both registers are full.
module rtcp_compound_parser import rtcp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// field_kind, field_value, entry_index, error_code, end_of_packet
	output logic [47:0]      m_tdata,
	output logic [7:0]       m_tuser,   // packet_type
	output logic             m_tlast,   // end_of_datagram
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [1:0]  cfg_data
);
	logic v_s1, l_s1, step, emit;
	logic [7:0] b_s1;
	logic chk_q;
	logic [1:0] ver_q;
	rec_t rec, r_q;
	logic ov_q;

	assign step = v_s1 && (!ov_q || m_tready);
	assign s_tready = !v_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; ov_q <= 1'b0; chk_q <= 1'b1; ver_q <= 2'd2;
		end else begin
			if (s_tready) v_s1 <= s_tvalid;
			if (step) ov_q <= emit;
			else if (m_tready) ov_q <= 1'b0;
			if (cfg_we && cfg_index == REG_CHECK) chk_q <= cfg_data[0];
			if (cfg_we && cfg_index == REG_VER) ver_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin b_s1 <= s_tdata; l_s1 <= s_tlast; end
		if (step) r_q <= rec;
	end

	rtcp_core u_core (
		.clk, .arst_n, .step, .b(b_s1), .last(l_s1),
		.chk_first(chk_q), .exp_ver(ver_q), .rec, .emit
	);

	assign m_tvalid = ov_q;
	assign m_tdata = {2'd0, r_q.end_of_packet, r_q.error_code, r_q.entry_index,
		r_q.field_value, r_q.field_kind};
	assign m_tuser = r_q.packet_type;
	assign m_tlast = r_q.end_of_datagram;
endmodule
`default_nettype wire

// File: rtl/rtcp_core.sv
// Parse state and per-byte decode logic of the RTCP parser.
// Depends on rtcp_pkg.
`default_nettype none
module rtcp_core import rtcp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] b,
	input  wire logic       last,
	input  wire logic       chk_first,
	input  wire logic [1:0] exp_ver,
	output rec_t            rec,
	output logic            emit
);
	logic [4:0] ph_q, ph_n;
	logic [31:0] ws_q, ws_n, sh;
	logic [1:0] biw_q, biw_n;
	logic [4:0] ecnt_q, ecnt_n, enum_q, enum_n, en1;
	logic [15:0] wl_q, wl_n, wl1;
	logic [7:0] bl_q, bl_n, bl1, sl_q, sl_n, ct_q, ct_n, b0, pt;
	logic fp_q, fp_n, wend, eop;
	logic [2:0] err;

	always_comb begin
		sh = {ws_q[23:0], b};
		ws_n = sh;
		ph_n = ph_q; biw_n = biw_q; ecnt_n = ecnt_q; enum_n = enum_q;
		wl_n = wl_q; bl_n = bl_q; sl_n = sl_q; ct_n = ct_q; fp_n = fp_q;
		wend = (biw_q == 2'd3);
		b0 = sh[31:24]; pt = sh[23:16];
		en1 = enum_q + 5'd1;
		wl1 = wl_q - 16'd1;
		bl1 = bl_q - 8'd1;
		emit = 1'b0; err = E_OK; eop = 1'b0;
		rec.field_kind = K_HDR; rec.field_value = '0; rec.entry_index = '0;
		if (ph_q == PH_DROP) begin
		end else if (ph_q == PH_HDR) begin
			if (wend) begin
				biw_n = 2'd0;
				emit = 1'b1; rec.field_value = sh;
				ct_n = pt; ecnt_n = b0[4:0]; enum_n = '0;
				wl_n = sh[15:0]; bl_n = '0; sl_n = '0;
				if (b0[7:6] != exp_ver) err = E_VER;
				else if (chk_first && fp_q) begin
					if (pt != PT_SR && pt != PT_RR) err = E_FIRST;
					else if (b0[5]) err = E_PAD;
				end
				if (err != E_OK) ph_n = PH_DROP;
				else begin
					fp_n = 1'b0;
					if (sh[15:0] == 16'd0) eop = 1'b1;
					else if (pt == PT_SR || pt == PT_RR) ph_n = 5'd1;
					else if (pt == PT_SDES) ph_n = (b0[4:0] != 5'd0) ? PH_CHUNK : PH_SKIP;
					else if (pt == PT_BYE) ph_n = (b0[4:0] != 5'd0) ? PH_BSRC : PH_RLEN;
					else ph_n = PH_SKIP;
				end
			end else biw_n = biw_q + 2'd1;
		end else begin
			case (ph_q)
				5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd10, 5'd11, 5'd12,
				5'd13: begin
					if (wend) begin
						emit = 1'b1; rec.field_kind = ph_q; rec.field_value = sh;
						rec.entry_index = (ph_q >= 5'd7) ? enum_q : 5'd0;
						if (ph_q == 5'd1)
							ph_n = (ct_q == PT_SR) ? 5'd2 :
								((ecnt_q != 5'd0) ? 5'd7 : PH_SKIP);
						else if (ph_q == 5'd6) ph_n = (ecnt_q != 5'd0) ? 5'd7 : PH_SKIP;
						else if (ph_q == 5'd7) ph_n = PH_LOSS;
						else if (ph_q == 5'd13) begin
							enum_n = en1;
							ph_n = (en1 == ecnt_q) ? PH_SKIP : 5'd7;
						end else ph_n = ph_q + 5'd1;
					end
				end
				PH_LOSS: begin
					if (biw_q == 2'd0) begin
						emit = 1'b1; rec.field_kind = K_FRAC; rec.field_value = {24'd0, b};
						rec.entry_index = enum_q;
					end else if (wend) begin
						emit = 1'b1; rec.field_kind = K_CUM; rec.entry_index = enum_q;
						rec.field_value = {8'd0, sh[23:0]}; ph_n = 5'd10;
					end
				end
				PH_CHUNK: begin
					if (wend) begin
						emit = 1'b1; rec.field_kind = K_CSSRC; rec.field_value = sh;
						rec.entry_index = enum_q; ph_n = PH_ITYPE;
					end
				end
				PH_ITYPE: begin
					emit = 1'b1; rec.field_kind = K_ITYPE; rec.field_value = {24'd0, b};
					rec.entry_index = enum_q;
					if (b == 8'd0) begin
						if (wend) begin
							enum_n = en1; ph_n = (en1 == ecnt_q) ? PH_SKIP : PH_CHUNK;
						end else ph_n = PH_PAD;
					end else ph_n = (b == SDES_PRIV) ? PH_PNAME : PH_ILEN;
				end
				PH_ILEN: begin
					emit = 1'b1; rec.field_kind = K_ILEN; rec.field_value = {24'd0, b};
					rec.entry_index = enum_q; sl_n = '0;
					if (b == 8'd0) ph_n = PH_ITYPE;
					else begin bl_n = b; ph_n = PH_DATA; end
				end
				PH_PNAME: begin
					emit = 1'b1; rec.field_kind = K_ILEN; rec.field_value = {24'd0, b};
					rec.entry_index = enum_q; bl_n = b; ph_n = PH_PVAL;
				end
				PH_PVAL: begin
					emit = 1'b1; rec.field_kind = K_ILEN; rec.field_value = {24'd0, b};
					rec.entry_index = enum_q;
					if (bl_q == 8'd0) begin
						sl_n = '0;
						if (b == 8'd0) ph_n = PH_ITYPE;
						else begin bl_n = b; ph_n = PH_DATA; end
					end else begin sl_n = b; ph_n = PH_DATA; end
				end
				PH_DATA: begin
					emit = 1'b1; rec.field_kind = K_IDATA; rec.field_value = {24'd0, b};
					rec.entry_index = enum_q; bl_n = bl1;
					if (bl1 == 8'd0) begin
						if (sl_q != 8'd0) begin bl_n = sl_q; sl_n = '0; end
						else ph_n = PH_ITYPE;
					end
				end
				PH_PAD: begin
					if (wend) begin
						enum_n = en1; ph_n = (en1 == ecnt_q) ? PH_SKIP : PH_CHUNK;
					end
				end
				PH_BSRC: begin
					if (wend) begin
						emit = 1'b1; rec.field_kind = K_BSRC; rec.field_value = sh;
						rec.entry_index = enum_q; enum_n = en1;
						if (en1 == ecnt_q) ph_n = PH_RLEN;
					end
				end
				PH_RLEN: begin
					emit = 1'b1; rec.field_kind = K_RLEN; rec.field_value = {24'd0, b};
					if (b == 8'd0) ph_n = PH_SKIP;
					else begin bl_n = b; ph_n = PH_RTXT; end
				end
				PH_RTXT: begin
					emit = 1'b1; rec.field_kind = K_RTXT; rec.field_value = {24'd0, b};
					bl_n = bl1;
					if (bl1 == 8'd0) ph_n = PH_SKIP;
				end
				default: begin
				end
			endcase
			if (wend) begin
				biw_n = 2'd0; wl_n = wl1;
				if (wl1 == 16'd0) eop = 1'b1;
			end else biw_n = biw_q + 2'd1;
		end
		rec.packet_type = ct_n;
		if (eop) begin
			emit = 1'b1;
			ph_n = PH_HDR; biw_n = '0; ct_n = '0; ecnt_n = '0; enum_n = '0;
			wl_n = '0; bl_n = '0; sl_n = '0;
		end
		if (last) begin
			emit = 1'b1;
			if (!eop && err == E_OK && ph_q != PH_DROP) err = E_TRUNC;
			ph_n = PH_HDR; ws_n = '0; biw_n = '0; ecnt_n = '0; enum_n = '0;
			wl_n = '0; bl_n = '0; sl_n = '0; ct_n = '0; fp_n = 1'b1;
		end
		rec.error_code = err;
		rec.end_of_packet = eop;
		rec.end_of_datagram = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HDR; ws_q <= '0; biw_q <= '0; ecnt_q <= '0; enum_q <= '0;
			wl_q <= '0; bl_q <= '0; sl_q <= '0; ct_q <= '0; fp_q <= 1'b1;
		end else if (step) begin
			ph_q <= ph_n; ws_q <= ws_n; biw_q <= biw_n; ecnt_q <= ecnt_n;
			enum_q <= enum_n; wl_q <= wl_n; bl_q <= bl_n; sl_q <= sl_n;
			ct_q <= ct_n; fp_q <= fp_n;
		end
	end
endmodule
`default_nettype wire

// File: rtl/rtcp_checker.sv
// Port-level checker for the RTCP parser, bound to the top level.
// Depends on rtcp_compound_parser ports only.
`default_nettype none
module rtcp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[44:42] <= 3'd4)
		else $error("error code out of range");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4:0] <= 5'd20)
		else $error("field kind out of range");
	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[44:42] == 3'd4 |-> m_tlast && !m_tdata[45])
		else $error("truncation reported off datagram end");
endmodule
bind rtcp_compound_parser rtcp_checker u_chk (.*);
`default_nettype wire
